// ===== design/bmp24_stream_decoder_top_defines.svh =====
// Assertion macros for the BMP stream decoder.
`ifndef BMP24_STREAM_DECODER_TOP_DEFINES_SVH
`define BMP24_STREAM_DECODER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Checked while out of reset.
`define BSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked in reset as well.
`define BSD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define BSD_ASSERT(lbl, prop, msg)
`define BSD_ASSERT_RST(lbl, prop, msg)

`endif

`endif

// ===== design/bsd_pkg.sv =====
package bsd_pkg;

  typedef enum logic [2:0] {
    MODE_HEADER = 3'd0,
    MODE_SKIP   = 3'd1,
    MODE_PIXEL  = 3'd2,
    MODE_PAD    = 3'd3,
    MODE_HALT   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    KIND_PIXEL      = 2'd0,
    KIND_BAD_SIG    = 2'd1,
    KIND_BAD_INFO   = 2'd2,
    KIND_COMPRESSED = 2'd3
  } kind_e;

  localparam logic [7:0]  SigB       = 8'h42;
  localparam logic [7:0]  SigM       = 8'h4D;
  localparam logic [7:0]  InfoSize   = 8'h28;
  localparam logic [31:0] HdrBytes   = 32'd54;
  localparam logic [31:0] PosSig0    = 32'd0;
  localparam logic [31:0] PosSig1    = 32'd1;
  localparam logic [31:0] PosOffset  = 32'd10;
  localparam logic [31:0] PosInfo    = 32'd14;
  localparam logic [31:0] PosWidth   = 32'd18;
  localparam logic [31:0] PosHeight  = 32'd22;
  localparam logic [31:0] PosCompr   = 32'd30;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic [23:0] pixel;
    logic        last_pixel;
  } result_t;

endpackage

// ===== design/bsd_stream_if.sv =====
interface bsd_in_if;
  import bsd_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;

  modport source (output valid, output data_byte, output start_of_file, input ready);
  modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

interface bsd_out_if;
  import bsd_pkg::*;

  logic        valid;
  logic        ready;
  kind_e       kind;
  logic [23:0] pixel;
  logic        last_pixel;

  modport source (output valid, output kind, output pixel, output last_pixel, input ready);
  modport sink   (input valid, input kind, input pixel, input last_pixel, output ready);
endinterface

// ===== design/bsd_in_stage.sv =====
module bsd_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  bsd_pkg::item_t item_i,
  input  logic          adv_i,
  output logic          valid_o,
  output bsd_pkg::item_t item_o
);
  import bsd_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  take;

  assign ready_o = !valid_q || adv_i;
  assign take    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

// ===== design/bsd_parser.sv =====
module bsd_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  bsd_pkg::item_t  item_i,
  output logic            emit_o,
  output bsd_pkg::result_t res_o
);
  import bsd_pkg::*;

  mode_e       mode_q, mode_d, mode_c;
  logic [31:0] pos_q, pos_d, pos_c;
  logic [31:0] off_q, off_d, off_c;
  logic [31:0] wid_q, wid_d, wid_c;
  logic [31:0] hgt_q, hgt_d, hgt_c;
  logic [31:0] col_q, col_d, col_c;
  logic [31:0] row_q, row_d, row_c;
  logic [1:0]  phase_q, phase_d, phase_c;
  logic [15:0] part_q, part_d, part_c;
  logic [1:0]  pad_q, pad_d, pad_c;
  logic [7:0]  b;
  logic [31:0] pos_inc, col_inc, row_inc;
  logic [1:0]  pad_dec;
  logic        empty_img;

  assign b = item_i.data_byte;

  // Start of file restarts the parser from the reset state.
  always_comb begin
    if (item_i.start_of_file) begin
      mode_c  = MODE_HEADER;
      pos_c   = '0;
      off_c   = '0;
      wid_c   = '0;
      hgt_c   = '0;
      col_c   = '0;
      row_c   = '0;
      phase_c = '0;
      part_c  = '0;
      pad_c   = '0;
    end else begin
      mode_c  = mode_q;
      pos_c   = pos_q;
      off_c   = off_q;
      wid_c   = wid_q;
      hgt_c   = hgt_q;
      col_c   = col_q;
      row_c   = row_q;
      phase_c = phase_q;
      part_c  = part_q;
      pad_c   = pad_q;
    end
  end

  assign pos_inc   = pos_c + 32'd1;
  assign col_inc   = col_c + 32'd1;
  assign row_inc   = row_c + 32'd1;
  assign pad_dec   = pad_c - 2'd1;
  assign empty_img = (wid_c == '0) || (hgt_c == '0);

  always_comb begin
    mode_d  = mode_c;
    pos_d   = pos_c;
    off_d   = off_c;
    wid_d   = wid_c;
    hgt_d   = hgt_c;
    col_d   = col_c;
    row_d   = row_c;
    phase_d = phase_c;
    part_d  = part_c;
    pad_d   = pad_c;
    emit_o  = 1'b0;
    res_o   = '{kind: KIND_PIXEL, pixel: '0, last_pixel: 1'b0};

    unique case (mode_c)
      MODE_HEADER: begin
        priority if ((pos_c == PosSig0 && b != SigB) || (pos_c == PosSig1 && b != SigM)) begin
          emit_o     = 1'b1;
          res_o.kind = KIND_BAD_SIG;
          mode_d     = MODE_HALT;
        end else if (pos_c == PosInfo && b != InfoSize) begin
          emit_o     = 1'b1;
          res_o.kind = KIND_BAD_INFO;
          mode_d     = MODE_HALT;
        end else if (pos_c == PosCompr && b != 8'h00) begin
          emit_o     = 1'b1;
          res_o.kind = KIND_COMPRESSED;
          mode_d     = MODE_HALT;
        end else begin
          for (int k = 0; k < 4; k++) begin
            if (pos_c == PosOffset + 32'(k)) off_d[8*k +: 8] = b;
            if (pos_c == PosWidth + 32'(k))  wid_d[8*k +: 8] = b;
            if (pos_c == PosHeight + 32'(k)) hgt_d[8*k +: 8] = b;
          end
          pos_d = pos_inc;
          if (pos_inc >= HdrBytes) begin
            if (off_c <= HdrBytes) begin
              col_d   = '0;
              row_d   = '0;
              phase_d = '0;
              part_d  = '0;
              pad_d   = '0;
              mode_d  = empty_img ? MODE_HALT : MODE_PIXEL;
            end else begin
              mode_d = MODE_SKIP;
            end
          end
        end
      end
      MODE_SKIP: begin
        pos_d = pos_inc;
        if (pos_inc >= off_c) begin
          col_d   = '0;
          row_d   = '0;
          phase_d = '0;
          part_d  = '0;
          pad_d   = '0;
          mode_d  = empty_img ? MODE_HALT : MODE_PIXEL;
        end
      end
      MODE_PIXEL: begin
        unique case (phase_c)
          2'd0: begin
            part_d  = {b, 8'h00};
            phase_d = 2'd1;
          end
          2'd1: begin
            part_d  = {part_c[15:8], b};
            phase_d = 2'd2;
          end
          default: begin
            phase_d     = 2'd0;
            emit_o      = 1'b1;
            res_o.pixel = {part_c, b};
            if (col_inc >= wid_c) begin
              col_d = '0;
              row_d = row_inc;
              if (row_inc >= hgt_c) begin
                res_o.last_pixel = 1'b1;
                mode_d           = MODE_HALT;
              end else begin
                pad_d = wid_c[1:0];
                if (wid_c[1:0] != 2'd0) mode_d = MODE_PAD;
              end
            end else begin
              col_d = col_inc;
            end
          end
        endcase
      end
      MODE_PAD: begin
        pad_d = pad_dec;
        if (pad_dec == 2'd0) mode_d = MODE_PIXEL;
      end
      default: begin
        mode_d = mode_c;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_HEADER;
      pos_q   <= '0;
      off_q   <= '0;
      wid_q   <= '0;
      hgt_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
      phase_q <= '0;
      part_q  <= '0;
      pad_q   <= '0;
    end else if (adv_i) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      off_q   <= off_d;
      wid_q   <= wid_d;
      hgt_q   <= hgt_d;
      col_q   <= col_d;
      row_q   <= row_d;
      phase_q <= phase_d;
      part_q  <= part_d;
      pad_q   <= pad_d;
    end
  end
endmodule

// ===== design/bsd_out_stage.sv =====
module bsd_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  bsd_pkg::result_t res_i,
  input  logic             ready_i,
  output logic             free_o,
  output logic             valid_o,
  output bsd_pkg::result_t res_o
);
  import bsd_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;
endmodule

// ===== design/bmp24_stream_decoder_top.sv =====
// 24-bit uncompressed BMP decoder, fed one file byte per transaction.
// in_i carries data_byte and start_of_file; start_of_file restarts the parser
// on that byte. out_o carries kind, pixel and last_pixel: a pixel
// (kind 0) for every three pixel bytes, or one error code after which the
// parser ignores bytes until the next start_of_file.
// Each byte is registered in the input register, then parsed combinationally
// into the result register, from which its result is offered on out_o.
// Throughput: one byte per cycle while the result register is free or being
// drained, set by the single parse step between the input and result registers.
// Reset clears the parser to the header state and drops any held byte and
// result. While the receiver stalls, the result register holds its
// transaction; the input register still takes one more byte, then in_i.ready
// falls until the result is taken. Bytes that give no result keep flowing
// only while the result register is free or being drained.
module bmp24_stream_decoder_top (
  input  logic clk_i,
  input  logic rst_ni,
  bsd_in_if.sink    in_i,
  bsd_out_if.source out_o
);
  import bsd_pkg::*;

  `include "bmp24_stream_decoder_top_defines.svh"

  item_t   in_item, stg_item;
  result_t par_res, out_res;
  logic    stg_valid, adv, emit, out_free, in_ready;

  assign in_item.data_byte     = in_i.data_byte;
  assign in_item.start_of_file = in_i.start_of_file;
  assign adv                   = stg_valid && out_free;
  assign in_i.ready            = in_ready;

  bsd_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_ready),
    .item_i  (in_item),
    .adv_i   (adv),
    .valid_o (stg_valid),
    .item_o  (stg_item)
  );

  bsd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (stg_item),
    .emit_o (emit),
    .res_o  (par_res)
  );

  bsd_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (adv && emit),
    .res_i   (par_res),
    .ready_i (out_o.ready),
    .free_o  (out_free),
    .valid_o (out_o.valid),
    .res_o   (out_res)
  );

  assign out_o.kind       = out_res.kind;
  assign out_o.pixel      = out_res.pixel;
  assign out_o.last_pixel = out_res.last_pixel;

  `BSD_ASSERT_RST(a_no_out_in_reset, !rst_ni |=> !out_o.valid, "result valid during reset")
  `BSD_ASSERT(a_err_payload_zero,
              (out_o.valid && out_o.kind != KIND_PIXEL) |-> (out_o.pixel == '0 && !out_o.last_pixel),
              "error transaction with non-zero pixel fields")
  `BSD_ASSERT(a_stall_cause, !in_ready |-> (stg_valid && out_o.valid && !out_o.ready),
              "input stalled without a held result")
  `BSD_ASSERT(a_no_overwrite, (out_o.valid && !out_o.ready) |=> !$past(adv && emit),
              "result register overwritten while stalled")
endmodule

// ===== bench/bmp24_stream_decoder_top_tb.sv =====
`timescale 1ns / 1ps

module bmp24_stream_decoder_top_tb;
  import bsd_pkg::*;

  localparam int StallLimit = 2000;
  localparam int RandomBytes = 900;

  logic clk_i;
  logic rst_ni;

  bsd_in_if  in_bus ();
  bsd_out_if out_bus ();

  bmp24_stream_decoder_top uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // decoder image
  mode_e       pmode;
  logic [31:0] pos;
  logic [31:0] offset;
  logic [31:0] width;
  logic [31:0] height;
  logic [31:0] col;
  logic [31:0] row;
  logic [1:0]  phase;
  logic [15:0] partial;
  logic [1:0]  pad;

  result_t     decoded_fifo[$];
  result_t     want;
  bit [7:0]    file_bytes[$];
  int          mismatches;
  int          bytes_sent;
  int          quiet;
  bit          tx_steady;
  bit          rx_steady;
  int          rx_count;
  int          stall;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task clear_decoder();
    pmode   = MODE_HEADER;
    pos     = '0;
    offset  = '0;
    width   = '0;
    height  = '0;
    col     = '0;
    row     = '0;
    phase   = '0;
    partial = '0;
    pad     = '0;
  endtask

  task enter_pixels();
    col     = '0;
    row     = '0;
    phase   = '0;
    partial = '0;
    pad     = '0;
    pmode   = (width == 0 || height == 0) ? MODE_HALT : MODE_PIXEL;
  endtask

  task decode_byte(input logic [7:0] b, input logic sof);
    result_t res;
    logic    emit;
    emit           = 1'b0;
    res.kind       = KIND_PIXEL;
    res.pixel      = '0;
    res.last_pixel = 1'b0;
    if (sof) clear_decoder();
    case (pmode)
      MODE_HEADER: begin
        if ((pos == PosSig0 && b != SigB) || (pos == PosSig1 && b != SigM)) begin
          res.kind = KIND_BAD_SIG;
          emit     = 1'b1;
        end else if (pos == PosInfo && b != InfoSize) begin
          res.kind = KIND_BAD_INFO;
          emit     = 1'b1;
        end else if (pos == PosCompr && b != 8'h00) begin
          res.kind = KIND_COMPRESSED;
          emit     = 1'b1;
        end
        if (emit) begin
          pmode = MODE_HALT;
        end else begin
          if (pos >= PosOffset && pos < PosOffset + 4)
            offset = offset | (32'(b) << (8 * (pos - PosOffset)));
          if (pos >= PosWidth && pos < PosWidth + 4)
            width = width | (32'(b) << (8 * (pos - PosWidth)));
          if (pos >= PosHeight && pos < PosHeight + 4)
            height = height | (32'(b) << (8 * (pos - PosHeight)));
          pos = pos + 1;
          if (pos >= HdrBytes) begin
            if (offset <= HdrBytes) enter_pixels();
            else pmode = MODE_SKIP;
          end
        end
      end
      MODE_SKIP: begin
        pos = pos + 1;
        if (pos >= offset) enter_pixels();
      end
      MODE_PIXEL: begin
        case (phase)
          2'd0: begin
            partial = {b, 8'h00};
            phase   = 2'd1;
          end
          2'd1: begin
            partial[7:0] = b;
            phase        = 2'd2;
          end
          default: begin
            phase     = 2'd0;
            res.pixel = {partial, b};
            emit      = 1'b1;
            col       = col + 1;
            if (col >= width) begin
              col = '0;
              row = row + 1;
              if (row >= height) begin
                res.last_pixel = 1'b1;
                pmode          = MODE_HALT;
              end else begin
                pad = width[1:0];
                if (pad != 0) pmode = MODE_PAD;
              end
            end
          end
        endcase
      end
      MODE_PAD: begin
        pad = pad - 1;
        if (pad == 0) pmode = MODE_PIXEL;
      end
      default: ;
    endcase
    if (emit) decoded_fifo.push_back(res);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        if (decoded_fifo.size() == 0) begin
          $error("unexpected transaction: kind %0d pixel %h last %0b",
                 out_bus.kind, out_bus.pixel, out_bus.last_pixel);
          mismatches++;
        end else begin
          want = decoded_fifo.pop_front();
          if (out_bus.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_bus.kind);
            mismatches++;
          end
          if (out_bus.pixel !== want.pixel) begin
            $error("pixel: expected %h, got %h", want.pixel, out_bus.pixel);
            mismatches++;
          end
          if (out_bus.last_pixel !== want.last_pixel) begin
            $error("last_pixel: expected %0b, got %0b", want.last_pixel,
                   out_bus.last_pixel);
            mismatches++;
          end
        end
      end
      if (in_bus.valid && in_bus.ready) decode_byte(in_bus.data_byte, in_bus.start_of_file);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= StallLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // result side back-pressure
  initial begin
    out_bus.ready = 1'b0;
    rx_count      = 0;
    @(posedge rst_ni);
    forever begin
      if (rx_count % 32 == 0) rx_steady = ($urandom_range(0, 2) == 0);
      stall = rx_steady ? 0 : $urandom_range(0, 7);
      @(negedge clk_i);
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
      rx_count++;
    end
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task send_byte(input logic [7:0] b, input logic sof);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid         <= 1'b1;
    in_bus.data_byte     <= b;
    in_bus.start_of_file <= sof;
    do @(posedge clk_i); while (!in_bus.ready);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task send_file(input bit sof_mark);
    tx_steady = ($urandom_range(0, 3) == 0);
    foreach (file_bytes[i]) send_byte(file_bytes[i], sof_mark && i == 0);
  endtask

  task add_random(input int n);
    repeat (n) file_bytes.push_back($urandom_range(0, 255));
  endtask

  task cut_file(input int n);
    while (file_bytes.size() > n) void'(file_bytes.pop_back());
  endtask

  task build_header(input logic [31:0] ofs, input logic [31:0] w, input logic [31:0] h);
    file_bytes.delete();
    add_random(int'(HdrBytes));
    file_bytes[PosSig0] = SigB;
    file_bytes[PosSig1] = SigM;
    file_bytes[PosInfo] = InfoSize;
    file_bytes[PosCompr] = 8'h00;
    for (int k = 0; k < 4; k++) begin
      file_bytes[PosOffset + k] = ofs[8*k +: 8];
      file_bytes[PosWidth + k]  = w[8*k +: 8];
      file_bytes[PosHeight + k] = h[8*k +: 8];
    end
  endtask

  task add_body(input logic [31:0] ofs, input logic [31:0] w, input logic [31:0] h);
    if (ofs > HdrBytes) add_random(ofs - HdrBytes);
    for (int r = 0; r < h; r++) begin
      add_random(3 * w);
      if (r != h - 1) add_random(w % 4);
    end
  endtask

  // first bytes after reset carry no start mark
  task test_no_start_mark();
    build_header(HdrBytes, 1, 1);
    repeat (3) file_bytes.push_back(8'hFF);
    add_random(2);
    send_file(1'b0);
  endtask

  task test_bad_signature();
    file_bytes = '{8'h00, 8'hFF};
    send_file(1'b1);
    file_bytes = '{SigB, 8'hFF, SigM};
    send_file(1'b1);
  endtask

  task test_bad_info_size();
    build_header(HdrBytes, 2, 2);
    file_bytes[PosInfo] = 8'h00;
    cut_file(20);
    send_file(1'b1);
  endtask

  task test_compressed();
    build_header(HdrBytes, 2, 2);
    file_bytes[PosCompr] = 8'hFF;
    cut_file(34);
    send_file(1'b1);
  endtask

  // widths 1..4 give every padding length; odd widths put the offset inside the header
  task test_row_padding();
    for (int w = 1; w <= 4; w++) begin
      build_header(w % 2 ? 32'd0 : HdrBytes, w, 2);
      add_body(w % 2 ? 32'd0 : HdrBytes, w, 2);
      send_file(1'b1);
    end
  endtask

  task test_offset_skip();
    build_header(60, 1, 1);
    add_body(60, 1, 1);
    repeat (3) void'(file_bytes.pop_back());
    repeat (3) file_bytes.push_back(8'h00);
    add_random(3);
    send_file(1'b1);
  endtask

  task test_empty_image();
    build_header(HdrBytes, 0, 3);
    add_random(6);
    send_file(1'b1);
    build_header(HdrBytes, 3, 0);
    add_random(6);
    send_file(1'b1);
  endtask

  task test_restart();
    build_header(HdrBytes, 2, 2);
    add_body(HdrBytes, 2, 2);
    cut_file(int'(HdrBytes) + 4);
    send_file(1'b1);
    build_header(HdrBytes, 1, 2);
    add_body(HdrBytes, 1, 2);
    send_file(1'b1);
  endtask

  task test_large_dims();
    build_header(HdrBytes, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_random(30);
    send_file(1'b1);
    build_header(32'hFFFF_FFFF, 1, 1);
    add_random(20);
    send_file(1'b1);
  endtask

  task test_random_files();
    int          pick;
    int          spot;
    int          stop_at;
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] ofs;
    stop_at = bytes_sent + RandomBytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      w    = $urandom_range(1, 8);
      h    = $urandom_range(1, 4);
      ofs  = $urandom_range(0, 1) ? $urandom_range(0, 54) : $urandom_range(55, 80);
      if (pick >= 86 && pick < 90) begin
        if ($urandom_range(0, 1)) w = 0;
        else h = 0;
      end
      if (pick >= 90 && pick < 95) begin
        w = $urandom();
        h = $urandom();
      end
      build_header(ofs, w, h);
      if (pick < 90) add_body(ofs, w, h);
      else add_random(30);
      if (pick < 70 && $urandom_range(0, 9) == 0) add_random($urandom_range(1, 4));
      if (pick >= 70 && pick < 78) begin
        case ($urandom_range(0, 3))
          0:       spot = PosSig0;
          1:       spot = PosSig1;
          2:       spot = PosInfo;
          default: spot = PosCompr;
        endcase
        file_bytes[spot] = file_bytes[spot] ^ 8'($urandom_range(1, 255));
        cut_file(spot + 1 + $urandom_range(0, 5));
      end
      if (pick >= 78 && pick < 86) cut_file($urandom_range(1, file_bytes.size()));
      if (pick >= 95) begin
        file_bytes.delete();
        add_random($urandom_range(1, 20));
      end
      send_file(1'b1);
    end
  endtask

  initial begin
    rst_ni               = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.data_byte     = '0;
    in_bus.start_of_file = 1'b0;
    mismatches           = 0;
    bytes_sent           = 0;
    tx_steady            = 1'b0;
    clear_decoder();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_no_start_mark();
    test_bad_signature();
    test_bad_info_size();
    test_compressed();
    test_row_padding();
    test_offset_skip();
    test_empty_image();
    test_restart();
    test_large_dims();
    test_random_files();

    in_bus.valid <= 1'b0;
    while (decoded_fifo.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/bsd_pkg.sv
design/bsd_stream_if.sv
design/bsd_in_stage.sv
design/bsd_parser.sv
design/bsd_out_stage.sv
design/bmp24_stream_decoder_top.sv
bench/bmp24_stream_decoder_top_tb.sv
